// ===== hdl/mf_pkg.sv =====
`default_nettype none

package mf_pkg;

    // Fixed field widths
    localparam int PIX_W = 8;
    localparam int POS_W = 10;
    localparam int CFG_W = 11;
    localparam int IDX_W = 2;

    // Default frame limits and queue depth
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    // Register reset values
    localparam logic [CFG_W-1:0] RST_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0] RST_HEIGHT = CFG_W'(480);
    localparam logic [PIX_W-1:0] RST_SEED   = PIX_W'(255);

    typedef enum logic [IDX_W-1:0] {
        CFG_IMAGE_WIDTH      = 2'd0,
        CFG_IMAGE_HEIGHT     = 2'd1,
        CFG_INITIAL_MAX_GREY = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic [PIX_W-1:0] seed;
    } cfg_t;

    // 3x3 window, index row*3+col
    typedef logic [8:0][PIX_W-1:0] win_t;

    // One window handed from the front to the back
    typedef struct packed {
        win_t             win;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             done;
        logic             reseed;
        logic [PIX_W-1:0] seed;
    } mf_item_t;

    // Compare and swap: lower value ends at index i
    function automatic win_t pix_sort(win_t p, int i, int j);
        win_t             q;
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        q = p;
        a = p[i];
        b = p[j];
        if (a > b)
        begin
            q[i] = b;
            q[j] = a;
        end
        return q;
    endfunction

    // Median network, layers one to three: sort each row
    function automatic win_t med9_rows(win_t p);
        win_t q;
        q = p;
        q = pix_sort(q, 1, 2);
        q = pix_sort(q, 4, 5);
        q = pix_sort(q, 7, 8);
        q = pix_sort(q, 0, 1);
        q = pix_sort(q, 3, 4);
        q = pix_sort(q, 6, 7);
        q = pix_sort(q, 1, 2);
        q = pix_sort(q, 4, 5);
        q = pix_sort(q, 7, 8);
        return q;
    endfunction

    // Layers four and five: merge across rows
    function automatic win_t med9_cols(win_t p);
        win_t q;
        q = p;
        q = pix_sort(q, 0, 3);
        q = pix_sort(q, 5, 8);
        q = pix_sort(q, 4, 7);
        q = pix_sort(q, 3, 6);
        q = pix_sort(q, 1, 4);
        q = pix_sort(q, 2, 5);
        return q;
    endfunction

    // Last four layers: median settles at index four
    function automatic logic [PIX_W-1:0] med9_final(win_t p);
        win_t q;
        q = p;
        q = pix_sort(q, 4, 7);
        q = pix_sort(q, 4, 2);
        q = pix_sort(q, 6, 4);
        q = pix_sort(q, 4, 2);
        return q[4];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/median_filter_3x3.sv =====
`default_nettype none

// 3x3 median filter on a raster stream of 8-bit grey pixels. One pixel is
// taken per clock and, once the pipeline is full, one result per clock
// leaves while m_tready is high and no result finds the queue full; the
// rate is set by the line store, read when a pixel is taken and written
// back from the stage after acceptance, and by the three-stage sorting
// network. A pixel at row r, column c with r and c of at least two yields
// the median of the window centred one row up and one column left; border
// pixels yield nothing. The running maximum is reseeded from initial_max_grey
// at frame start (tuser) and after the last pixel of a frame; tlast marks
// the result of the last pixel. Line store contents are undefined after
// reset and need no clearing pass: only real pixels reach a result window.
// Frame size is clamped to three up to MAX_WIDTH by MAX_HEIGHT.
module median_filter_3x3 #(
    parameter int MAX_WIDTH  = mf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mf_pkg::DEF_MAX_HEIGHT
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        cfg_we,
    input  wire  [mf_pkg::IDX_W-1:0]   cfg_index,
    input  wire  [mf_pkg::CFG_W-1:0]   cfg_data,
    input  wire                        s_tvalid,
    output logic                       s_tready,
    input  wire  [7:0]                 s_tdata,   // [7:0] pixel_in
    input  wire                        s_tuser,   // [0] frame_start
    output logic                       m_tvalid,
    input  wire                        m_tready,
    // [7:0] median_out, [17:8] out_row, [27:18] out_col, [35:28] max_grey
    output logic [39:0]                m_tdata,
    output logic                       m_tlast    // frame_done
);
    import mf_pkg::*;

    cfg_t             cfg_reg;
    logic             push;
    mf_item_t         push_item;
    logic             q_full;
    logic             pop;
    mf_item_t         pop_item;
    logic             q_empty;
    logic [PIX_W-1:0] out_median;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic [PIX_W-1:0] out_max;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= RST_WIDTH;
            cfg_reg.height <= RST_HEIGHT;
            cfg_reg.seed   <= RST_SEED;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:      cfg_reg.width  <= cfg_data;
                CFG_IMAGE_HEIGHT:     cfg_reg.height <= cfg_data;
                CFG_INITIAL_MAX_GREY: cfg_reg.seed   <= cfg_data[PIX_W-1:0];
                default:              ;
            endcase
        end
    end

    mf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_pixel       (s_tdata[PIX_W-1:0]),
        .in_frame_start (s_tuser),
        .push           (push),
        .push_item      (push_item),
        .q_full         (q_full)
    );

    mf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    mf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop        (pop),
        .pop_item   (pop_item),
        .q_empty    (q_empty),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_median (out_median),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_max    (out_max),
        .out_done   (m_tlast)
    );

    // Pack result fields, lowest first
    assign m_tdata = {4'b0000, out_max, out_col, out_row, out_median};

endmodule

`default_nettype wire

// ===== hdl/mf_front.sv =====
`default_nettype none

module mf_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  mf_pkg::cfg_t               cfg,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  wire  [mf_pkg::PIX_W-1:0]   in_pixel,
    input  wire                        in_frame_start,
    output logic                       push,
    output mf_pkg::mf_item_t           push_item,
    input  wire                        q_full
);
    import mf_pkg::*;

    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
    localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 2;
    localparam int WW = ((CFG_W > $clog2(MAX_WIDTH + 1)) ? CFG_W : $clog2(MAX_WIDTH + 1)) + 1;
    localparam int HW = ((CFG_W > $clog2(MAX_HEIGHT + 1)) ? CFG_W : $clog2(MAX_HEIGHT + 1)) + 1;
    localparam int LW = 2 * PIX_W;

    // Line store: upper byte two rows back, lower byte one row back
    logic [LW-1:0] line_mem [MAX_WIDTH];
    logic [LW-1:0] line_q_reg;

    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic          reseed_reg;
    logic [PIX_W-1:0] seed_reg;

    // Stage after acceptance
    logic             f1_valid_reg;
    logic [PIX_W-1:0] f1_pix_reg;
    logic [CW-1:0]    f1_addr_reg;
    logic             f1_result_reg;
    logic             f1_done_reg;
    logic [POS_W-1:0] f1_row_reg;
    logic [POS_W-1:0] f1_col_reg;
    logic             f1_reseed_reg;
    logic [PIX_W-1:0] f1_seed_reg;

    logic             byp_reg;
    logic [LW-1:0]    byp_data_reg;
    win_t             win_reg;
    win_t             win_next;

    logic [WW-1:0] w_raw;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_raw;
    logic [HW-1:0] h_eff;
    logic [WW-1:0] cx;
    logic [HW-1:0] rx;
    logic [RW-1:0] r0;
    logic [CW-1:0] c0;
    logic [RW-1:0] rm1;
    logic [CW-1:0] cm1;
    logic          accept;
    logic          f1_adv;
    logic          wr_en;
    logic          wrap;
    logic          is_result;
    logic          is_done;
    logic [LW-1:0] line_eff;
    logic [LW-1:0] wr_data;

    // Clamp frame size
    always_comb
    begin
        w_raw = WW'(cfg.width);
        h_raw = HW'(cfg.height);
        if (w_raw < WW'(3))
            w_eff = WW'(3);
        else if (w_raw > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = w_raw;
        if (h_raw < HW'(3))
            h_eff = HW'(3);
        else if (h_raw > HW'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = h_raw;
    end

    // Stall the stage only when a result finds the queue full
    assign f1_adv   = !f1_valid_reg || !f1_result_reg || !q_full;
    assign in_ready = f1_adv;
    assign accept   = in_valid && in_ready;
    assign wr_en    = f1_valid_reg && f1_adv;
    assign push     = f1_valid_reg && f1_result_reg && !q_full;

    // Position of the incoming item and classification
    always_comb
    begin
        r0        = in_frame_start ? '0 : row_reg;
        c0        = in_frame_start ? '0 : col_reg;
        cx        = WW'(c0);
        rx        = HW'(r0);
        rm1       = r0 - RW'(1);
        cm1       = c0 - CW'(1);
        is_result = (cx >= WW'(2)) && (rx >= HW'(2)) && (cx < w_eff) && (rx < h_eff);
        is_done   = (rx == h_eff - HW'(1)) && (cx == w_eff - WW'(1));
        wrap      = 1'b0;
        row_next  = r0;
        if (cx + WW'(1) >= w_eff)
        begin
            col_next = '0;
            if (rx + HW'(1) >= h_eff)
            begin
                row_next = '0;
                wrap     = 1'b1;
            end
            else
            begin
                row_next = r0 + RW'(1);
            end
        end
        else
        begin
            col_next = c0 + CW'(1);
        end
    end

    // Advance position and the reseed marker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg    <= '0;
            col_reg    <= '0;
            reseed_reg <= 1'b1;
            seed_reg   <= RST_SEED;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            if (wrap)
            begin
                reseed_reg <= 1'b1;
                seed_reg   <= cfg.seed;
            end
            else if (in_frame_start)
            begin
                reseed_reg <= !is_result;
                seed_reg   <= cfg.seed;
            end
            else if (is_result)
            begin
                reseed_reg <= 1'b0;
            end
        end
    end

    // Stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else if (f1_adv)
        begin
            f1_valid_reg <= accept;
            if (accept)
                byp_reg <= wr_en && (c0 == f1_addr_reg);
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_pix_reg    <= in_pixel;
            f1_addr_reg   <= c0;
            f1_result_reg <= is_result;
            f1_done_reg   <= is_done;
            f1_row_reg    <= POS_W'(rm1);
            f1_col_reg    <= POS_W'(cm1);
            f1_reseed_reg <= reseed_reg || in_frame_start;
            f1_seed_reg   <= in_frame_start ? cfg.seed : seed_reg;
            byp_data_reg  <= wr_data;
        end
    end

    // Read line store on accept
    always_ff @(posedge clk)
    begin
        if (accept)
            line_q_reg <= line_mem[c0];
    end

    // Write back shifted rows
    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[f1_addr_reg] <= wr_data;
    end

    // Forward data written at the address just read
    always_comb
    begin
        line_eff = byp_reg ? byp_data_reg : line_q_reg;
        wr_data  = {line_eff[PIX_W-1:0], f1_pix_reg};
    end

    // Shift window by one column
    always_comb
    begin
        win_next    = win_reg;
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = line_eff[LW-1:PIX_W];
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = line_eff[PIX_W-1:0];
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = f1_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (wr_en)
            win_reg <= win_next;
    end

    // Result item toward the queue
    always_comb
    begin
        push_item.win    = win_next;
        push_item.row    = f1_row_reg;
        push_item.col    = f1_col_reg;
        push_item.done   = f1_done_reg;
        push_item.reseed = f1_reseed_reg;
        push_item.seed   = f1_seed_reg;
    end

endmodule

`default_nettype wire

// ===== hdl/mf_queue.sv =====
`default_nettype none

module mf_queue (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     push,
    input  mf_pkg::mf_item_t        push_item,
    output logic                    full,
    input  wire                     pop,
    output mf_pkg::mf_item_t        pop_item,
    output logic                    empty
);
    import mf_pkg::*;

    mf_item_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = slot_reg[rd_ptr_reg];

    // Track pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Store item
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

// ===== hdl/mf_back.sv =====
`default_nettype none

module mf_back (
    input  wire                      clk,
    input  wire                      rst_n,
    output logic                     pop,
    input  mf_pkg::mf_item_t         pop_item,
    input  wire                      q_empty,
    output logic                     out_valid,
    input  wire                      out_ready,
    output logic [mf_pkg::PIX_W-1:0] out_median,
    output logic [mf_pkg::POS_W-1:0] out_row,
    output logic [mf_pkg::POS_W-1:0] out_col,
    output logic [mf_pkg::PIX_W-1:0] out_max,
    output logic                     out_done
);
    import mf_pkg::*;

    logic             adv;
    logic             s0_valid_reg;
    logic             s1_valid_reg;
    logic             o_valid_reg;
    mf_item_t         s0_reg;
    mf_item_t         s0_next;
    mf_item_t         s1_reg;
    mf_item_t         s1_next;
    logic [PIX_W-1:0] run_max_reg;
    logic [PIX_W-1:0] o_med_reg;
    logic [POS_W-1:0] o_row_reg;
    logic [POS_W-1:0] o_col_reg;
    logic [PIX_W-1:0] o_max_reg;
    logic             o_done_reg;
    logic [PIX_W-1:0] med;
    logic [PIX_W-1:0] base;
    logic [PIX_W-1:0] max_new;

    // Whole sort pipeline moves when the output slot frees
    assign adv = !o_valid_reg || out_ready;
    assign pop = adv && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= !q_empty;
            s1_valid_reg <= s0_valid_reg;
            o_valid_reg  <= s1_valid_reg;
        end
    end

    // Sort layers ahead of each stage register
    always_comb
    begin
        s0_next     = pop_item;
        s0_next.win = med9_rows(pop_item.win);
        s1_next     = s0_reg;
        s1_next.win = med9_cols(s0_reg.win);
    end

    // Sort stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg <= s0_next;
            s1_reg <= s1_next;
        end
    end

    // Finish the median and fold it into the running maximum
    always_comb
    begin
        med     = med9_final(s1_reg.win);
        base    = s1_reg.reseed ? s1_reg.seed : run_max_reg;
        max_new = (med > base) ? med : base;
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            run_max_reg <= max_new;
            o_med_reg   <= med;
            o_row_reg   <= s1_reg.row;
            o_col_reg   <= s1_reg.col;
            o_max_reg   <= max_new;
            o_done_reg  <= s1_reg.done;
        end
    end

    assign out_valid  = o_valid_reg;
    assign out_median = o_med_reg;
    assign out_row    = o_row_reg;
    assign out_col    = o_col_reg;
    assign out_max    = o_max_reg;
    assign out_done   = o_done_reg;

endmodule

`default_nettype wire
